// ===== hw/rtl/b5gb_pkg.sv =====
// Shared types and constants for the Big5 / GB2312 stream converter.
// Used by every converter module except the table memory; depends on nothing else.
package b5gb_pkg;

  // Table sizes.
  localparam int unsigned Big5Entries = 13973;
  localparam int unsigned GbEntries   = 7614;

  // Field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 14;
  localparam int unsigned WordW  = 16;

  // Row lengths of the two code layouts.
  localparam logic [7:0] Big5RowLen = 8'd157;
  localparam logic [7:0] GbRowLen   = 8'd94;

  // Byte range limits.
  localparam logic [7:0] LeadLo      = 8'ha1;
  localparam logic [7:0] Big5LeadHi  = 8'hf9;
  localparam logic [7:0] Big5LowLo   = 8'h40;
  localparam logic [7:0] Big5LowHi   = 8'h7e;
  localparam logic [7:0] TrailHiLo   = 8'ha1;
  localparam logic [7:0] TrailHiHi   = 8'hfe;
  localparam logic [7:0] GbSymLeadHi = 8'ha9;
  localparam logic [7:0] GbHanLeadLo = 8'hb0;
  localparam logic [7:0] GbHanLeadHi = 8'hf7;

  // Column offsets: upper trail bytes follow the 63 lower ones in a Big5 row,
  // and GB hanzi rows follow the nine symbol rows.
  localparam logic [7:0] Big5UpperColBase = 8'h62;
  localparam logic [7:0] GbHanRowBase     = 8'ha7;

  // Substitution pairs.
  localparam logic [7:0] SubHi     = 8'ha1;
  localparam logic [7:0] B2gSubLo  = 8'hf5;
  localparam logic [7:0] G2bSubLo  = 8'hbc;

  // Direction and command codes.
  localparam logic DirB2g = 1'b0;
  localparam logic DirG2b = 1'b1;
  localparam logic CmdData  = 1'b0;
  localparam logic CmdTable = 1'b1;
  localparam logic SelB2g = 1'b0;
  localparam logic SelG2b = 1'b1;

  // Output queue.
  localparam int unsigned OutDepth = 8;
  localparam int unsigned PtrW     = 3;
  localparam int unsigned CntW     = 4;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } out_entry_t;

  typedef struct packed {
    logic              valid;
    logic [IndexW-1:0] index;
  } lookup_t;

  // Registered lookup stage control.
  typedef struct packed {
    logic [1:0] cnt;
    logic       pair;
    logic       sub;
    logic       dir;
  } stage_ctrl_t;

endpackage

// ===== hw/rtl/b5gb_table_ram.sv =====
// Single-port-write, single-port-read synchronous table memory.
// Read data is registered; no package dependency.
module b5gb_table_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/b5gb_index_decode.sv =====
// Checks a lead/trail pair for the current direction and computes its table index.
// Depends on b5gb_pkg for byte ranges and row lengths.
module b5gb_index_decode #(
  parameter int unsigned Big5Entries = b5gb_pkg::Big5Entries,
  parameter int unsigned GbEntries   = b5gb_pkg::GbEntries
) (
  input  logic                   dir_i,
  input  logic [7:0]             lead_i,
  input  logic [7:0]             trail_i,
  output b5gb_pkg::lookup_t      lookup_o
);

  localparam logic [14:0] Big5Lim = 15'(Big5Entries);
  localparam logic [14:0] GbLim   = 15'(GbEntries);

  logic       b2g_ok;
  logic       g2b_ok;
  logic       trail_upper;
  logic       trail_lower;
  logic [6:0] row;
  logic [7:0] col;
  logic [7:0] row_len;
  logic [14:0] idx;

  always_comb begin
    trail_upper = (trail_i >= b5gb_pkg::TrailHiLo) && (trail_i <= b5gb_pkg::TrailHiHi);
    trail_lower = (trail_i >= b5gb_pkg::Big5LowLo) && (trail_i <= b5gb_pkg::Big5LowHi);
    b2g_ok = (lead_i >= b5gb_pkg::LeadLo) && (lead_i <= b5gb_pkg::Big5LeadHi)
             && (trail_upper || trail_lower);
    g2b_ok = trail_upper
             && (((lead_i >= b5gb_pkg::LeadLo) && (lead_i <= b5gb_pkg::GbSymLeadHi))
                 || ((lead_i >= b5gb_pkg::GbHanLeadLo) && (lead_i <= b5gb_pkg::GbHanLeadHi)));

    if (dir_i == b5gb_pkg::DirG2b) begin
      row_len = b5gb_pkg::GbRowLen;
      col     = trail_i - b5gb_pkg::TrailHiLo;
      // Hanzi rows sit after the nine symbol rows.
      if (lead_i <= b5gb_pkg::GbSymLeadHi) begin
        row = 7'(lead_i - b5gb_pkg::LeadLo);
      end else begin
        row = 7'(lead_i - b5gb_pkg::GbHanRowBase);
      end
    end else begin
      row_len = b5gb_pkg::Big5RowLen;
      row     = 7'(lead_i - b5gb_pkg::LeadLo);
      if (trail_lower) begin
        col = trail_i - b5gb_pkg::Big5LowLo;
      end else begin
        col = trail_i - b5gb_pkg::Big5UpperColBase;
      end
    end

    idx = (15'(row) * 15'(row_len)) + 15'(col);

    if (dir_i == b5gb_pkg::DirG2b) begin
      lookup_o.valid = g2b_ok && (idx < GbLim);
    end else begin
      lookup_o.valid = b2g_ok && (idx < Big5Lim);
    end
    lookup_o.index = idx[b5gb_pkg::IndexW-1:0];
  end

endmodule

// ===== hw/rtl/b5gb_out_fifo.sv =====
// Output byte queue: takes up to two bytes per cycle, hands out one per transfer.
// Depends on b5gb_pkg for the entry type and queue depth.
module b5gb_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_cnt_i,
  input  b5gb_pkg::out_entry_t              push0_i,
  input  b5gb_pkg::out_entry_t              push1_i,
  output logic [b5gb_pkg::CntW-1:0]         count_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output b5gb_pkg::out_entry_t              out_o
);

  b5gb_pkg::out_entry_t mem [b5gb_pkg::OutDepth];

  logic [b5gb_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [b5gb_pkg::PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [b5gb_pkg::CntW-1:0] count_q, count_d;
  logic                      pop;

  assign pop         = (count_q != '0) && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_o       = mem[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + b5gb_pkg::PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + b5gb_pkg::PtrW'(pop);
    count_d  = count_q + b5gb_pkg::CntW'(push_cnt_i) - b5gb_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_ptr_q + b5gb_pkg::PtrW'(1)] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, count_q} + 5'(push_cnt_i)) <= 5'(b5gb_pkg::OutDepth)))
    else $error("output queue overflow");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b5gb_pkg::PtrW'(count_q) == (wr_ptr_q - rd_ptr_q)))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/big5_gb2312_stream_converter_core.sv =====
// Big5 / GB2312 byte-stream converter, top level.
// Depends on b5gb_pkg, b5gb_index_decode, b5gb_table_ram and b5gb_out_fifo.

// The converter accepts one input item per cycle, whether a stream byte or a
// table write, as long as its output queue has room for two more bytes. A
// stream byte passes the registered lookup stage and then the output queue:
// the lookup stage decodes the pair and reads the selected table memory, and
// result formation forms the output bytes and queues them. A completed pair
// leaves as two output transfers, one per cycle while the output is ready, so
// the sustained rate is one byte in and on average one byte out per cycle,
// bounded by the single output port. Table writes take effect at their transfer
// edge and are seen by any later pair. The direction register is written through
// the cfg channel, which is always ready, and must only change while the converter is idle.
module big5_gb2312_stream_converter_core #(
  parameter int unsigned Big5Entries = b5gb_pkg::Big5Entries,
  parameter int unsigned GbEntries   = b5gb_pkg::GbEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        table_select_i,
  input  logic [13:0] table_index_i,
  input  logic [15:0] table_word_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);

  localparam int unsigned B5AddrW = $clog2(Big5Entries);
  localparam int unsigned GbAddrW = $clog2(GbEntries);
  localparam logic [14:0] Big5Lim = 15'(Big5Entries);
  localparam logic [14:0] GbLim   = 15'(GbEntries);

  logic dir_q;
  logic lead_pending_q, lead_pending_d;
  logic [7:0] lead_byte_q, lead_byte_d;

  b5gb_pkg::stage_ctrl_t s1_q, s1_d;
  logic [7:0] s1_byte_q, s1_byte_d;
  logic       s1_last_q, s1_last_d;

  b5gb_pkg::lookup_t lookup;
  logic accept;
  logic is_data;
  logic b5_we, gb_we, b5_re, gb_re;
  logic [15:0] b5_rdata, gb_rdata;
  logic [15:0] pair_word;

  logic [b5gb_pkg::CntW-1:0] fifo_count;
  b5gb_pkg::out_entry_t push0, push1, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= b5gb_pkg::DirB2g;
    end else if (cfg_valid_i) begin
      dir_q <= cfg_data_i;
    end
  end

  // Room for the worst case of two bytes, counting what the lookup stage still holds.
  assign in_ready_o = (({1'b0, fifo_count} + 5'(s1_q.cnt)) <= 5'(b5gb_pkg::OutDepth - 2));
  assign accept     = in_valid_i && in_ready_o;
  assign is_data    = (command_i == b5gb_pkg::CmdData);

  b5gb_index_decode #(
    .Big5Entries (Big5Entries),
    .GbEntries   (GbEntries)
  ) u_decode (
    .dir_i    (dir_q),
    .lead_i   (lead_byte_q),
    .trail_i  (data_byte_i),
    .lookup_o (lookup)
  );

  always_comb begin
    b5_we = accept && !is_data && (table_select_i == b5gb_pkg::SelB2g)
            && ({1'b0, table_index_i} < Big5Lim);
    gb_we = accept && !is_data && (table_select_i == b5gb_pkg::SelG2b)
            && ({1'b0, table_index_i} < GbLim);
    b5_re = accept && is_data && lead_pending_q && lookup.valid
            && (dir_q == b5gb_pkg::DirB2g);
    gb_re = accept && is_data && lead_pending_q && lookup.valid
            && (dir_q == b5gb_pkg::DirG2b);
  end

  // Items are taken at most one per cycle, so a write and a read never share a cycle,
  // and a read issued after a write already sees the new word.
  b5gb_table_ram #(
    .Depth (Big5Entries),
    .Width (b5gb_pkg::WordW)
  ) u_b5_table (
    .clk_i   (clk_i),
    .we_i    (b5_we),
    .waddr_i (table_index_i[B5AddrW-1:0]),
    .wdata_i (table_word_i),
    .re_i    (b5_re),
    .raddr_i (lookup.index[B5AddrW-1:0]),
    .rdata_o (b5_rdata)
  );

  b5gb_table_ram #(
    .Depth (GbEntries),
    .Width (b5gb_pkg::WordW)
  ) u_gb_table (
    .clk_i   (clk_i),
    .we_i    (gb_we),
    .waddr_i (table_index_i[GbAddrW-1:0]),
    .wdata_i (table_word_i),
    .re_i    (gb_re),
    .raddr_i (lookup.index[GbAddrW-1:0]),
    .rdata_o (gb_rdata)
  );

  // Lead tracking and the lookup stage.
  always_comb begin
    lead_pending_d = lead_pending_q;
    lead_byte_d    = lead_byte_q;
    s1_d.cnt       = 2'd0;
    s1_d.pair      = 1'b0;
    s1_d.sub       = 1'b0;
    s1_d.dir       = dir_q;
    s1_byte_d      = data_byte_i;
    s1_last_d      = last_i;

    if (accept && is_data) begin
      if (lead_pending_q) begin
        lead_pending_d = 1'b0;
        s1_d.cnt       = 2'd2;
        s1_d.pair      = 1'b1;
        s1_d.sub       = !lookup.valid;
      end else if (data_byte_i[7]) begin
        if (last_i) begin
          // A dangling lead byte ends the string with the first substitution byte.
          s1_d.cnt  = 2'd1;
          s1_byte_d = b5gb_pkg::SubHi;
        end else begin
          lead_pending_d = 1'b1;
          lead_byte_d    = data_byte_i;
        end
      end else begin
        s1_d.cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      lead_byte_q    <= '0;
      s1_q           <= '0;
    end else begin
      lead_pending_q <= lead_pending_d;
      lead_byte_q    <= lead_byte_d;
      s1_q           <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_byte_q <= s1_byte_d;
    s1_last_q <= s1_last_d;
  end

  // Result formation.
  always_comb begin
    if (s1_q.sub) begin
      pair_word = {b5gb_pkg::SubHi,
                   (s1_q.dir == b5gb_pkg::DirG2b) ? b5gb_pkg::G2bSubLo : b5gb_pkg::B2gSubLo};
    end else if (s1_q.dir == b5gb_pkg::DirG2b) begin
      pair_word = gb_rdata;
    end else begin
      pair_word = b5_rdata;
    end

    if (s1_q.pair) begin
      push0.data = pair_word[15:8];
      push0.last = 1'b0;
    end else begin
      push0.data = s1_byte_q;
      push0.last = s1_last_q;
    end
    push1.data = pair_word[7:0];
    push1.last = s1_last_q;
  end

  b5gb_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (s1_q.cnt),
    .push0_i     (push0),
    .push1_i     (push1),
    .count_o     (fifo_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign out_byte_o = head.data;
  assign out_last_o = head.last;

`ifndef ASSERT_OFF
  a_stage_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.cnt != 2'd3) && (!s1_q.pair || (s1_q.cnt == 2'd2)))
    else $error("lookup stage byte count inconsistent");

  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({b5_re, gb_re, b5_we, gb_we}))
    else $error("more than one table access in a cycle");

  a_pair_from_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.pair |-> $past(lead_pending_q))
    else $error("pair completed without a pending lead byte");

  a_write_keeps_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_data) |=> ($stable(lead_pending_q) && $stable(lead_byte_q)))
    else $error("table write disturbed the pending lead byte");
`endif

endmodule
